// ===== hdl/pha_pkg.sv =====
// ----------------------------------------------------------------------------
// pha_pkg
// Shared types, register codes and the arctangent table of the pointer
// heading core.
// ----------------------------------------------------------------------------
`default_nettype none

package pha_pkg;

  localparam int CORDIC_STAGES_DEF = 16;
  localparam int CORDIC_STAGES_MAX = 24;

  localparam int COORD_BITS = 12;
  localparam int PTR_W      = 12;
  localparam int CFG_W      = 13;
  localparam int IDX_W      = 2;
  localparam int HEAD_W     = 15;

  localparam logic [PTR_W-1:0] COORD_MASK =
    (COORD_BITS >= PTR_W) ? {PTR_W{1'b1}} : PTR_W'((1 << COORD_BITS) - 1);

  // magnitude bits, fraction bits, vector width with growth and sign
  localparam int MAG_W  = PTR_W;
  localparam int FRAC_W = 16;
  localparam int VEC_W  = MAG_W + FRAC_W + 3;
  localparam int ANG_W  = 24;
  localparam int TOT_W  = 25;

  localparam logic [CFG_W-1:0] SCREEN_WIDTH_RST  = CFG_W'(800);
  localparam logic [CFG_W-1:0] SCREEN_HEIGHT_RST = CFG_W'(600);

  localparam logic [IDX_W-1:0] REG_SCREEN_WIDTH  = IDX_W'(0);
  localparam logic [IDX_W-1:0] REG_SCREEN_HEIGHT = IDX_W'(1);

  // quadrant base codes
  localparam logic [1:0] BASE_0   = 2'd0;
  localparam logic [1:0] BASE_90  = 2'd1;
  localparam logic [1:0] BASE_180 = 2'd2;
  localparam logic [1:0] BASE_270 = 2'd3;

  localparam logic [ANG_W-2:0]  ANG_90    = (ANG_W-1)'(90 * 65536);
  localparam logic [HEAD_W-1:0] HEADING_MAX = HEAD_W'(23039);

  typedef struct packed {
    logic       valid;
    logic [1:0] base;
  } pha_ctl_t;

  function automatic logic signed [ANG_W-1:0] atan_entry(input int unsigned idx);
    logic signed [ANG_W-1:0] v;
    case (idx)
      0:  v = ANG_W'(2949120);
      1:  v = ANG_W'(1740967);
      2:  v = ANG_W'(919879);
      3:  v = ANG_W'(466945);
      4:  v = ANG_W'(234379);
      5:  v = ANG_W'(117304);
      6:  v = ANG_W'(58666);
      7:  v = ANG_W'(29335);
      8:  v = ANG_W'(14668);
      9:  v = ANG_W'(7334);
      10: v = ANG_W'(3667);
      11: v = ANG_W'(1833);
      12: v = ANG_W'(917);
      13: v = ANG_W'(458);
      14: v = ANG_W'(229);
      15: v = ANG_W'(115);
      16: v = ANG_W'(57);
      17: v = ANG_W'(29);
      18: v = ANG_W'(14);
      19: v = ANG_W'(7);
      20: v = ANG_W'(4);
      21: v = ANG_W'(2);
      22: v = ANG_W'(1);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/pha_if.sv =====
// ----------------------------------------------------------------------------
// pha_if
// Valid/ready channels of the pointer heading core: pointer samples in,
// headings out.
// ----------------------------------------------------------------------------
`default_nettype none

interface pha_sample_if;
  logic        valid;
  logic        ready;
  logic [11:0] pointer_x;
  logic [11:0] pointer_y;

  modport source (output valid, output pointer_x, output pointer_y, input ready);
  modport sink   (input valid, input pointer_x, input pointer_y, output ready);
endinterface

interface pha_result_if;
  logic        valid;
  logic        ready;
  logic [14:0] heading;

  modport source (output valid, output heading, input ready);
  modport sink   (input valid, input heading, output ready);
endinterface

`default_nettype wire

// ===== hdl/pointer_heading_angle_core.sv =====
// ----------------------------------------------------------------------------
// pointer_heading_angle_core
// Clockwise compass heading of a pointer around the screen centre, in
// 1/64 degree, from a pipelined CORDIC arctangent.
// ----------------------------------------------------------------------------
// The core takes one pointer sample per cycle while the result channel is
// not stalled. A sample passes a front stage that subtracts the screen
// centre and folds the offset into its quadrant, the CORDIC cells, and a
// back stage that adds the quadrant base, rounds and saturates. All stages
// advance together; a stall on the result channel holds the whole chain
// and drops ready on the sample channel. The user must write screen width
// and height through the cfg port while no sample is in flight; unchecked.
// ----------------------------------------------------------------------------
`default_nettype none

module pointer_heading_angle_core
  import pha_pkg::*;
#(
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_we,
  input  wire logic [IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_W-1:0]  cfg_data,
  pha_sample_if.sink             sample,
  pha_result_if.source           result
);

  logic [CFG_W-1:0] screen_width;
  logic [CFG_W-1:0] screen_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= SCREEN_WIDTH_RST;
      screen_height <= SCREEN_HEIGHT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SCREEN_WIDTH:  screen_width  <= cfg_data;
        REG_SCREEN_HEIGHT: screen_height <= cfg_data;
        default: ;
      endcase
    end
  end

  logic en;
  assign en           = !result.valid || result.ready;
  assign sample.ready = en;

  // front stage: centre offset and quadrant fold
  logic [PTR_W-1:0]        px;
  logic [PTR_W-1:0]        py;
  logic signed [MAG_W:0]   dx;
  logic signed [MAG_W:0]   dy;
  logic [MAG_W-1:0]        ax;
  logic [MAG_W-1:0]        ay;
  logic [MAG_W-1:0]        num;
  logic [MAG_W-1:0]        den;
  logic [1:0]              base_next;

  assign px = sample.pointer_x & COORD_MASK;
  assign py = sample.pointer_y & COORD_MASK;
  assign dx = $signed({1'b0, px}) - $signed({1'b0, screen_width[CFG_W-1:1]});
  assign dy = $signed({1'b0, py}) - $signed({1'b0, screen_height[CFG_W-1:1]});
  assign ax = dx[MAG_W] ? MAG_W'(-dx) : dx[MAG_W-1:0];
  assign ay = dy[MAG_W] ? MAG_W'(-dy) : dy[MAG_W-1:0];

  always_comb begin
    num       = '0;
    den       = '0;
    base_next = BASE_0;
    if (dy == '0) begin
      base_next = dx[MAG_W] ? BASE_270 : BASE_90;
    end else if (dx == '0) begin
      base_next = dy[MAG_W] ? BASE_0 : BASE_180;
    end else if (!dx[MAG_W] && !dy[MAG_W]) begin
      base_next = BASE_90;
      num       = ay;
      den       = ax;
    end else if (!dx[MAG_W]) begin
      base_next = BASE_0;
      num       = ax;
      den       = ay;
    end else if (dy[MAG_W]) begin
      base_next = BASE_270;
      num       = ay;
      den       = ax;
    end else begin
      base_next = BASE_180;
      num       = ax;
      den       = ay;
    end
  end

  pha_ctl_t                ctl [0:CORDIC_STAGES];
  logic signed [VEC_W-1:0] xv  [0:CORDIC_STAGES];
  logic signed [VEC_W-1:0] yv  [0:CORDIC_STAGES];
  logic signed [ANG_W-1:0] zv  [0:CORDIC_STAGES];

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl[0].valid <= 1'b0;
    end else if (en) begin
      ctl[0].valid <= sample.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctl[0].base <= base_next;
      xv[0]       <= $signed({3'b000, den, {FRAC_W{1'b0}}});
      yv[0]       <= $signed({3'b000, num, {FRAC_W{1'b0}}});
      zv[0]       <= '0;
    end
  end

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
    pha_cell #(
      .STAGE (i)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .en      (en),
      .ctl_in  (ctl[i]),
      .x_in    (xv[i]),
      .y_in    (yv[i]),
      .z_in    (zv[i]),
      .ctl_out (ctl[i+1]),
      .x_out   (xv[i+1]),
      .y_out   (yv[i+1]),
      .z_out   (zv[i+1])
    );
  end

  // back stage: clamp, add base, round, saturate
  logic signed [ANG_W-1:0] z_last;
  logic [ANG_W-2:0]        z_clamp;
  logic [TOT_W-1:0]        base_ang;
  logic [TOT_W-1:0]        total;
  logic [TOT_W-1:0]        rounded;
  logic [HEAD_W-1:0]       heading_next;

  assign z_last = zv[CORDIC_STAGES];

  always_comb begin
    if (z_last[ANG_W-1]) begin
      z_clamp = '0;
    end else if (z_last[ANG_W-2:0] > ANG_90) begin
      z_clamp = ANG_90;
    end else begin
      z_clamp = z_last[ANG_W-2:0];
    end
  end

  always_comb begin
    unique case (ctl[CORDIC_STAGES].base)
      BASE_0:   base_ang = '0;
      BASE_90:  base_ang = TOT_W'(ANG_90);
      BASE_180: base_ang = TOT_W'(2 * 90 * 65536);
      BASE_270: base_ang = TOT_W'(3 * 90 * 65536);
      default:  base_ang = '0;
    endcase
  end

  assign total        = base_ang + TOT_W'(z_clamp);
  assign rounded      = total + TOT_W'(512);
  assign heading_next = (rounded[TOT_W-1:10] > HEADING_MAX) ? HEADING_MAX
                                                           : rounded[TOT_W-1:10];

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (en) begin
      result.valid <= ctl[CORDIC_STAGES].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      result.heading <= heading_next;
    end
  end

  a_heading_range: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> result.heading <= HEADING_MAX)
    else $error("heading beyond full circle");

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.ready |-> !sample.ready)
    else $error("sample taken while result stalled");

  a_accept_enters_chain: assert property (@(posedge clk) disable iff (rst)
    sample.valid && sample.ready |=> ctl[0].valid)
    else $error("accepted beat lost at front stage");

  a_stall_holds_result: assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.ready |=> result.valid && $stable(result.heading))
    else $error("stalled result changed");

endmodule

`default_nettype wire

// ===== hdl/pha_cell.sv =====
// ----------------------------------------------------------------------------
// pha_cell
// One CORDIC vectoring cell: rotates the vector toward the x axis by the
// fixed angle of its stage and accumulates that angle.
// ----------------------------------------------------------------------------
`default_nettype none

module pha_cell
  import pha_pkg::*;
#(
  parameter int STAGE = 0
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    en,
  input  wire pha_ctl_t                ctl_in,
  input  wire logic signed [VEC_W-1:0] x_in,
  input  wire logic signed [VEC_W-1:0] y_in,
  input  wire logic signed [ANG_W-1:0] z_in,
  output pha_ctl_t                     ctl_out,
  output logic signed [VEC_W-1:0]      x_out,
  output logic signed [VEC_W-1:0]      y_out,
  output logic signed [ANG_W-1:0]      z_out
);

  localparam logic signed [ANG_W-1:0] STEP_ANG = atan_entry(STAGE);

  logic signed [VEC_W-1:0] xs;
  logic signed [VEC_W-1:0] ys;
  logic signed [VEC_W-1:0] x_next;
  logic signed [VEC_W-1:0] y_next;
  logic signed [ANG_W-1:0] z_next;

  assign xs = x_in >>> STAGE;
  assign ys = y_in >>> STAGE;

  always_comb begin
    x_next = x_in;
    y_next = y_in;
    z_next = z_in;
    if (y_in[VEC_W-1]) begin
      x_next = x_in - ys;
      y_next = y_in + xs;
      z_next = z_in - STEP_ANG;
    end else if (y_in != '0) begin
      x_next = x_in + ys;
      y_next = y_in - xs;
      z_next = z_in + STEP_ANG;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out.valid <= 1'b0;
    end else if (en) begin
      ctl_out.valid <= ctl_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctl_out.base <= ctl_in.base;
      x_out        <= x_next;
      y_out        <= y_next;
      z_out        <= z_next;
    end
  end

endmodule

`default_nettype wire
